FILE: hdl/command_driven_stack_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command driven stack
// Shared helpers that expect signals named clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef COMMAND_DRIVEN_STACK_TOP_ASSERT_SVH
`define COMMAND_DRIVEN_STACK_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define CDS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define CDS_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

FILE: hdl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Types and constants shared by the command driven stack modules.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        KIND_COUNT       = 3'd0,
        KIND_TOP         = 3'd1,
        KIND_TOP_EMPTY   = 3'd2,
        KIND_POPPED      = 3'd3,
        KIND_POP_ERROR   = 3'd4,
        KIND_DRAIN_EMPTY = 3'd5,
        KIND_OVERFLOW    = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_COUNT   = 3'd1,
        OP_PEEK    = 3'd2,
        OP_POP     = 3'd3,
        OP_POP_ERR = 3'd4,
        OP_DRAIN   = 3'd5
    } op_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  mag;
        logic              big;
    } cmd_t;

endpackage

FILE: hdl/cds_if.sv
// ----------------------------------------------------------------------------
// cds_in_if / cds_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface cds_in_if import cds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cds_out_if import cds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] data;
    logic                     last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

FILE: hdl/command_driven_stack_top.sv
// ----------------------------------------------------------------------------
// command_driven_stack_top
// LIFO stack of 32-bit signed numbers driven by a stream of command items.
// ----------------------------------------------------------------------------
// Path: a single-result item passes through the front register and the
//   queue entry to the result register; a peek also passes through the
//   registered memory read.
// Throughput: push, count and error items run at one per cycle unless the
//   result channel stalls; pops and drains walk S_POP and S_READ per entry.
// Reset: clears the entry count, the queue and all valid flags at once; the
//   stack memory is not cleared and entries are only read after a write.
module command_driven_stack_top import cds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cds_in_if.sink    cmd,
    cds_out_if.source result
);

    // Front end to queue.
    cmd_t front_data;
    logic front_valid;
    logic front_ready;

    // Queue to back end.
    cmd_t back_data;
    logic back_valid;
    logic back_ready;

    // Accept items and classify them by mode and value.
    cds_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_data  (front_data),
        .q_valid (front_valid),
        .q_ready (front_ready)
    );

    // Hold a couple of classified items so the front keeps accepting
    // while the back end walks a long pop or drain.
    cds_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_data),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_data),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // Execute against the stack memory; advance one result per output slot.
    cds_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (back_data),
        .q_valid (back_valid),
        .q_ready (back_ready),
        .result  (result)
    );

endmodule

FILE: hdl/cds_front.sv
// ----------------------------------------------------------------------------
// cds_front
// Accept command items and classify them into stack operations.
// ----------------------------------------------------------------------------
module cds_front import cds_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    cds_in_if.sink cmd,
    output cmd_t   q_data,
    output logic   q_valid,
    input  logic   q_ready
);

    cmd_t              cls;
    cmd_t              cmd_reg;
    logic              cmd_valid_reg;
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] neg_val;
    logic              accept;

    assign raw     = cmd.value;
    assign neg_val = ~raw + 1'b1;

    always_comb
    begin
        cls.value = raw;
        cls.mag   = neg_val[CNT_W-1:0];
        cls.big   = |neg_val[DATA_W-1:CNT_W];
        priority if (cmd.mode)
        begin
            cls.op = OP_DRAIN;
        end
        else if (raw == MOST_NEG)
        begin
            cls.op = OP_POP_ERR;
        end
        else if (raw[DATA_W-1])
        begin
            cls.op = OP_POP;
        end
        else if (raw == '0)
        begin
            cls.op = OP_COUNT;
        end
        else if (raw == DATA_W'(1))
        begin
            cls.op = OP_PEEK;
        end
        else
        begin
            cls.op = OP_PUSH;
        end
    end

    assign cmd.ready = !cmd_valid_reg || q_ready;
    assign accept    = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (q_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cls;
        end
    end

    assign q_data  = cmd_reg;
    assign q_valid = cmd_valid_reg;

endmodule

FILE: hdl/cds_queue.sv
// ----------------------------------------------------------------------------
// cds_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "command_driven_stack_top_assert.svh"

module cds_queue import cds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_data,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_data,
    output logic pop_valid,
    input  logic pop_ready
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `CDS_ASSERT_ALWAYS(a_queue_count, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

FILE: hdl/cds_back.sv
// ----------------------------------------------------------------------------
// cds_back
// Execute stack operations against the stack memory and register results.
// ----------------------------------------------------------------------------
`include "command_driven_stack_top_assert.svh"

module cds_back import cds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       q_data,
    input  logic       q_valid,
    output logic       q_ready,
    cds_out_if.source  result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  remain_reg;
    logic [CNT_W-1:0]  remain_next;
    kind_t             pend_kind_reg;
    kind_t             pend_kind_next;
    logic              pend_last_reg;
    logic              pend_last_next;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              rd_en;
    logic [CNT_W-1:0]  count_dec;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              load_out;
    kind_t             out_kind_next;
    logic [DATA_W-1:0] out_data_next;
    logic              out_last_next;
    logic              out_free;
    logic              full;
    logic              empty;

    assign out_free  = !out_valid_reg || result.ready;
    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - 1'b1;
    assign q_ready   = (state_reg == S_IDLE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        pend_kind_next = pend_kind_reg;
        pend_last_next = pend_last_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        load_out       = 1'b0;
        out_kind_next  = KIND_POP_ERROR;
        out_data_next  = '0;
        out_last_next  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    unique case (q_data.op)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                load_out      = 1'b1;
                                out_kind_next = KIND_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_COUNT:
                        begin
                            load_out      = 1'b1;
                            out_kind_next = KIND_COUNT;
                            out_data_next = DATA_W'(count_reg);
                        end
                        OP_PEEK:
                        begin
                            if (empty)
                            begin
                                load_out      = 1'b1;
                                out_kind_next = KIND_TOP_EMPTY;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                pend_kind_next = KIND_TOP;
                                pend_last_next = 1'b1;
                                state_next     = S_READ;
                            end
                        end
                        OP_POP:
                        begin
                            if (q_data.big || (q_data.mag >= count_reg))
                            begin
                                load_out      = 1'b1;
                                out_kind_next = KIND_POP_ERROR;
                            end
                            else
                            begin
                                remain_next = q_data.mag;
                                state_next  = S_POP;
                            end
                        end
                        OP_POP_ERR:
                        begin
                            load_out      = 1'b1;
                            out_kind_next = KIND_POP_ERROR;
                        end
                        OP_DRAIN:
                        begin
                            if (empty)
                            begin
                                load_out      = 1'b1;
                                out_kind_next = KIND_DRAIN_EMPTY;
                            end
                            else
                            begin
                                remain_next = count_reg;
                                state_next  = S_POP;
                            end
                        end
                        default:
                        begin
                            load_out      = 1'b1;
                            out_kind_next = KIND_POP_ERROR;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // Read the top entry and drop it from the stack.
                rd_en          = 1'b1;
                count_next     = count_dec;
                remain_next    = remain_reg - 1'b1;
                pend_kind_next = KIND_POPPED;
                pend_last_next = (remain_reg == CNT_W'(1));
                state_next     = S_READ;
            end
            S_READ:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    out_kind_next = pend_kind_reg;
                    out_data_next = rd_data_reg;
                    out_last_next = pend_last_reg;
                    state_next    = pend_last_reg ? S_IDLE : S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            pend_kind_reg <= KIND_POPPED;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            pend_kind_reg <= pend_kind_next;
            pend_last_reg <= pend_last_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[count_reg[ADDR_W-1:0]] <= q_data.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[count_dec[ADDR_W-1:0]];
        end
    end

    assign result.valid = out_valid_reg;
    assign result.kind  = out_kind_reg;
    assign result.data  = out_data_reg;
    assign result.last  = out_last_reg;

    `CDS_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(STACK_DEPTH), "entry count above depth")
    `CDS_ASSERT_ALWAYS(a_remain_fits, (state_reg != S_POP) || ((remain_reg != '0) && (remain_reg <= count_reg)), "pop run exceeds entry count")
    `CDS_ASSERT_NEXT(a_read_delivers, (state_reg == S_READ) && out_free, out_valid_reg, "read data not presented")

endmodule
